@@ design/lps_pkg.sv @@
// shared types, constants and lookup functions for the lighting program sequencer
package lps_pkg;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_FADE_CEILING   = 2'd0,
    REG_WHITE_SEPARATE = 2'd1
  } reg_index_t;

  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth  = 8;

  // program codes
  localparam logic [3:0] PROG_FIRST  = 4'd1;
  localparam logic [3:0] PROG_STATIC_LAST = 4'd6;
  localparam logic [3:0] PROG_STROBE = 4'd7;
  localparam logic [3:0] PROG_RAMP   = 4'd8;
  localparam logic [3:0] PROG_CROSS  = 4'd9;
  localparam logic [3:0] DEPTH_LAST  = 4'd9;

  // last phase of each sequence
  localparam logic [3:0] PHASE_SEQ_LAST   = 4'd13;
  localparam logic [3:0] PHASE_CROSS_LAST = 4'd7;

  localparam logic [7:0] LEVEL_FULL = 8'd255;

  // one request on the input channel
  typedef struct packed {
    logic [3:0] program_sel;
    logic [3:0] depth_sel;
    logic       tick;
  } in_item_t;

  // one result, also the channel level state
  typedef struct packed {
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic [7:0] white_level;
  } out_item_t;

  // configuration write strobe between top and core
  typedef struct packed {
    logic                     we;
    logic [CfgIndexWidth-1:0] index;
    logic [CfgDataWidth-1:0]  data;
  } cfg_write_t;

  // static colour level per depth
  function automatic logic [7:0] level_lut(input logic [3:0] d);
    logic [7:0] r;
    unique case (d)
      4'd0:    r = 8'd25;
      4'd1:    r = 8'd25;
      4'd2:    r = 8'd44;
      4'd3:    r = 8'd64;
      4'd4:    r = 8'd83;
      4'd5:    r = 8'd102;
      4'd6:    r = 8'd134;
      4'd7:    r = 8'd166;
      4'd8:    r = 8'd217;
      4'd9:    r = 8'd255;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // strobe half period per depth, already halved
  function automatic logic [9:0] strobe_half_lut(input logic [3:0] d);
    logic [9:0] r;
    unique case (d)
      4'd0:    r = 10'd350;
      4'd1:    r = 10'd350;
      4'd2:    r = 10'd300;
      4'd3:    r = 10'd250;
      4'd4:    r = 10'd200;
      4'd5:    r = 10'd175;
      4'd6:    r = 10'd150;
      4'd7:    r = 10'd125;
      4'd8:    r = 10'd100;
      4'd9:    r = 10'd50;
      default: r = 10'd0;
    endcase
    return r;
  endfunction

  // flashes per colour per depth
  function automatic logic [3:0] flashes_lut(input logic [3:0] d);
    logic [3:0] r;
    unique case (d)
      4'd0:    r = 4'd4;
      4'd1:    r = 4'd4;
      4'd2:    r = 4'd5;
      4'd3:    r = 4'd6;
      4'd4:    r = 4'd6;
      4'd5:    r = 4'd7;
      4'd6:    r = 4'd7;
      4'd7:    r = 4'd8;
      4'd8:    r = 4'd8;
      4'd9:    r = 4'd9;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // fade step time per depth
  function automatic logic [9:0] fade_lut(input logic [3:0] d);
    logic [9:0] r;
    unique case (d)
      4'd0:    r = 10'd20;
      4'd1:    r = 10'd20;
      4'd2:    r = 10'd15;
      4'd3:    r = 10'd10;
      4'd4:    r = 10'd6;
      4'd5:    r = 10'd5;
      4'd6:    r = 10'd4;
      4'd7:    r = 10'd3;
      4'd8:    r = 10'd2;
      4'd9:    r = 10'd1;
      default: r = 10'd0;
    endcase
    return r;
  endfunction

  // paint colour 0-6 at level v: red green blue purple yellow cyan white
  function automatic out_item_t paint(input logic [2:0] colour, input logic [7:0] v,
                                      input logic white_sep);
    out_item_t r;
    r = '0;
    unique case (colour)
      3'd0: r.red_level = v;
      3'd1: r.green_level = v;
      3'd2: r.blue_level = v;
      3'd3: begin
        r.red_level  = v;
        r.blue_level = v;
      end
      3'd4: begin
        r.red_level   = v;
        r.green_level = v;
      end
      3'd5: begin
        r.green_level = v;
        r.blue_level  = v;
      end
      default: begin
        if (white_sep) begin
          r.white_level = v;
        end else begin
          r.red_level   = v;
          r.green_level = v;
          r.blue_level  = v;
        end
      end
    endcase
    return r;
  endfunction

endpackage

@@ design/lps_if.sv @@
// valid/ready channel interfaces for requests and results

interface lps_in_if;
  import lps_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lps_out_if;
  import lps_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/led_lighting_program_sequencer_top.sv @@
// top level: request register, sequencer core and result handshake
// a taken request waits in the request register until the result slot is free
// throughput: one request per cycle unless results stall; one update pass in lps_core
// the result register is the channel level state itself and holds while stalled
// reset: synchronous active-high rst clears all state, levels to zero, ceiling to 255
module led_lighting_program_sequencer_top (
  input  logic                                clk,
  input  logic                                rst,
  lps_in_if.sink                              in_ch,
  lps_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [lps_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [lps_pkg::CfgDataWidth-1:0]    cfg_data
);
  import lps_pkg::*;

  logic       hold_valid;
  in_item_t   hold_item;
  logic       out_valid;
  logic       advance;
  cfg_write_t cfg;
  out_item_t  levels;

  assign cfg = '{we: cfg_we, index: cfg_index, data: cfg_data};

  // a held request moves on whenever the result slot is free or being taken
  assign advance      = hold_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready  = !hold_valid || advance;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = levels;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ch.ready) begin
      hold_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) hold_item <= in_ch.data;
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  lps_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (hold_item),
    .cfg     (cfg),
    .levels  (levels)
  );

endmodule

@@ design/lps_core.sv @@
// program state, configuration registers and the per-request update logic
module lps_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  lps_pkg::in_item_t  item,
  input  lps_pkg::cfg_write_t cfg,
  output lps_pkg::out_item_t levels
);
  import lps_pkg::*;

  logic [7:0] fade_ceiling;
  logic       white_separate;
  logic [3:0] step_phase, step_phase_next;
  logic [9:0] step_timer, step_timer_next;
  logic [3:0] flash_count, flash_count_next;
  logic [7:0] fade_level, fade_level_next;
  logic [3:0] prev_program, prev_program_next;
  logic [3:0] prev_depth, prev_depth_next;
  logic       restart_pending, restart_pending_next;
  out_item_t  levels_next;

  // working values after restart handling
  logic [9:0] timer_ticked;
  logic       item_ok;
  logic       restart;
  logic [3:0] ph;
  logic [9:0] tm;
  logic [3:0] fc;
  logic [7:0] up, dn, mx;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_ceiling   <= LEVEL_FULL;
      white_separate <= 1'b0;
    end else if (cfg.we) begin
      if (cfg.index == REG_FADE_CEILING) fade_ceiling <= cfg.data;
      if (cfg.index == REG_WHITE_SEPARATE) white_separate <= cfg.data[0];
    end
  end

  // next state for one request
  always_comb begin
    timer_ticked = (item.tick && step_timer != '0) ? step_timer - 10'd1 : step_timer;
    item_ok = (item.program_sel >= PROG_FIRST) && (item.program_sel <= PROG_CROSS) &&
              (item.depth_sel <= DEPTH_LAST);
    restart = restart_pending || item.program_sel != prev_program ||
              item.depth_sel != prev_depth;

    step_phase_next      = step_phase;
    step_timer_next      = timer_ticked;
    flash_count_next     = flash_count;
    fade_level_next      = fade_level;
    prev_program_next    = prev_program;
    prev_depth_next      = prev_depth;
    restart_pending_next = restart_pending;
    levels_next          = levels;

    ph = restart ? 4'd0 : step_phase;
    tm = restart ? 10'd0 : timer_ticked;
    fc = restart ? flashes_lut(item.depth_sel) : flash_count;
    up = fade_level;
    dn = fade_ceiling - fade_level;
    mx = (up > dn) ? up : dn;

    if (item_ok) begin
      prev_program_next    = item.program_sel;
      prev_depth_next      = item.depth_sel;
      restart_pending_next = 1'b0;
      if (item.program_sel <= PROG_STATIC_LAST) begin
        // static colour, painted once per restart
        if (restart) begin
          levels_next = paint(3'(item.program_sel - 4'd1), level_lut(item.depth_sel),
                              white_separate);
        end
      end else if (item.program_sel == PROG_STROBE) begin
        // strobe: even phase flashes on, odd phase off
        step_phase_next  = ph;
        step_timer_next  = tm;
        flash_count_next = fc;
        if (ph > PHASE_SEQ_LAST) begin
          step_phase_next = '0;
        end else if (tm == '0) begin
          step_timer_next = strobe_half_lut(item.depth_sel);
          if (!ph[0]) begin
            levels_next     = paint(ph[3:1], LEVEL_FULL, white_separate);
            step_phase_next = ph + 4'd1;
          end else begin
            levels_next = '0;
            if (fc > 4'd1) begin
              flash_count_next = fc - 4'd1;
              step_phase_next  = ph - 4'd1;
            end else begin
              flash_count_next = flashes_lut(item.depth_sel);
              step_phase_next  = (ph == PHASE_SEQ_LAST) ? 4'd0 : ph + 4'd1;
            end
          end
        end
      end else if (item.program_sel == PROG_RAMP) begin
        // fade: even phase rises to the ceiling, odd phase falls to zero
        step_phase_next = ph;
        step_timer_next = tm;
        if (ph > PHASE_SEQ_LAST) begin
          step_phase_next = '0;
        end else if (tm == '0) begin
          step_timer_next = fade_lut(item.depth_sel);
          if (!ph[0]) begin
            if (fade_level < fade_ceiling) begin
              levels_next     = paint(ph[3:1], fade_level, white_separate);
              fade_level_next = fade_level + 8'd1;
            end else begin
              step_phase_next = ph + 4'd1;
            end
          end else begin
            if (fade_level != '0) begin
              levels_next     = paint(ph[3:1], fade_level, white_separate);
              fade_level_next = fade_level - 8'd1;
            end else begin
              step_phase_next = (ph == PHASE_SEQ_LAST) ? 4'd0 : ph + 4'd1;
            end
          end
        end
      end else begin
        // cross fade; a restart or stray phase clears everything
        step_phase_next = ph;
        step_timer_next = tm;
        if (restart) begin
          fade_level_next = '0;
          levels_next     = '0;
        end
        if (ph > PHASE_CROSS_LAST) begin
          step_phase_next = '0;
          step_timer_next = '0;
          fade_level_next = '0;
          levels_next     = '0;
        end else if (tm == '0) begin
          step_timer_next = fade_lut(item.depth_sel);
          if (!restart && fade_level < fade_ceiling) begin
            unique case (ph[2:0])
              3'd0: levels_next = paint(3'd6, up, white_separate);
              3'd1: levels_next = white_separate ? out_item_t'{up, 8'd0, 8'd0, dn}
                                                 : out_item_t'{mx, dn, dn, 8'd0};
              3'd2: levels_next = '{dn, up, 8'd0, 8'd0};
              3'd3: levels_next = '{8'd0, dn, up, 8'd0};
              3'd4: levels_next = '{up, 8'd0, mx, 8'd0};
              3'd5: levels_next = '{mx, up, dn, 8'd0};
              3'd6: levels_next = '{dn, mx, up, 8'd0};
              default: levels_next = white_separate ? out_item_t'{8'd0, dn, dn, up}
                                                    : out_item_t'{up, mx, mx, 8'd0};
            endcase
            fade_level_next = fade_level + 8'd1;
          end else if (restart && fade_ceiling != '0) begin
            // level was just cleared to zero, so this is the first rising step
            unique case (ph[2:0])
              3'd0:    levels_next = paint(3'd6, 8'd0, white_separate);
              default: levels_next = '0;
            endcase
            fade_level_next = 8'd1;
          end else begin
            step_phase_next = (ph == PHASE_CROSS_LAST) ? 4'd1 : ph + 4'd1;
            fade_level_next = '0;
          end
        end
      end
    end
  end

  // state registers, updated as each request passes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_phase      <= '0;
      step_timer      <= '0;
      flash_count     <= '0;
      fade_level      <= '0;
      prev_program    <= '0;
      prev_depth      <= '0;
      restart_pending <= 1'b1;
      levels          <= '0;
    end else if (advance) begin
      step_phase      <= step_phase_next;
      step_timer      <= step_timer_next;
      flash_count     <= flash_count_next;
      fade_level      <= fade_level_next;
      prev_program    <= prev_program_next;
      prev_depth      <= prev_depth_next;
      restart_pending <= restart_pending_next;
      levels          <= levels_next;
    end
  end

endmodule

@@ tb/tb_led_lighting_program_sequencer_top.sv @@
// testbench for the lighting program sequencer: directed table, random runs, level predictor
`timescale 1ns / 100ps
module tb_led_lighting_program_sequencer_top;
  import lps_pkg::*;

  // program codes beyond the package names
  localparam logic [3:0] PROG_NONE      = 4'd0;
  localparam logic [3:0] PROG_RED       = 4'd1;
  localparam logic [3:0] PROG_GREEN     = 4'd2;
  localparam logic [3:0] PROG_BLUE      = 4'd3;
  localparam logic [3:0] PROG_PURPLE    = 4'd4;
  localparam logic [3:0] PROG_YELLOW    = 4'd5;
  localparam logic [3:0] PROG_CYAN      = 4'd6;
  localparam logic [3:0] PROG_PAST_LAST = 4'd10;
  localparam logic [3:0] PROG_TOP_CODE  = 4'd15;
  localparam logic [3:0] COLOUR_WHITE   = 4'd6;

  // per-depth tables
  localparam logic [7:0] STATIC_LEVEL [10] = '{25, 25, 44, 64, 83, 102, 134, 166, 217, 255};
  localparam logic [9:0] STROBE_PERIOD [10] =
    '{700, 700, 600, 500, 400, 350, 300, 250, 200, 100};
  localparam logic [3:0] FLASH_COUNT [10] = '{4, 4, 5, 6, 6, 7, 7, 8, 8, 9};
  localparam logic [9:0] FADE_STEP [10] = '{20, 20, 15, 10, 6, 5, 4, 3, 2, 1};
  // colour masks: bit0 red, bit1 green, bit2 blue, bit3 white
  localparam logic [3:0] COLOUR_MASK [7] = '{1, 2, 4, 5, 3, 6, 8};

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 80;
  localparam int NUM_PHASES  = 5;
  localparam logic [7:0] PHASE_CEILING [NUM_PHASES] = '{1, 255, 5, 60, 2};
  localparam logic       PHASE_WHITE [NUM_PHASES]   = '{0, 1, 1, 0, 1};

  // directed request table, levels filled in where obvious
  typedef struct packed {
    logic [3:0] pg;
    logic [3:0] dp;
    logic       tk;
    logic       known;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] w;
  } directed_row_t;

  localparam int NUM_DIRECTED = 25;
  localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
    '{PROG_NONE,      4'd0,  1'b0, 1'b1, 8'd0,   8'd0,   8'd0,   8'd0},
    '{PROG_TOP_CODE,  4'd15, 1'b1, 1'b1, 8'd0,   8'd0,   8'd0,   8'd0},
    '{PROG_RED,       4'd15, 1'b0, 1'b1, 8'd0,   8'd0,   8'd0,   8'd0},
    '{PROG_RED,       4'd0,  1'b0, 1'b1, 8'd25,  8'd0,   8'd0,   8'd0},
    '{PROG_GREEN,     4'd9,  1'b1, 1'b1, 8'd0,   8'd255, 8'd0,   8'd0},
    '{PROG_BLUE,      4'd9,  1'b0, 1'b1, 8'd0,   8'd0,   8'd255, 8'd0},
    '{PROG_PURPLE,    4'd5,  1'b1, 1'b1, 8'd102, 8'd0,   8'd102, 8'd0},
    '{PROG_YELLOW,    4'd8,  1'b0, 1'b1, 8'd217, 8'd217, 8'd0,   8'd0},
    '{PROG_CYAN,      4'd0,  1'b1, 1'b1, 8'd0,   8'd25,  8'd25,  8'd0},
    '{PROG_CYAN,      4'd0,  1'b0, 1'b1, 8'd0,   8'd25,  8'd25,  8'd0},
    '{PROG_PAST_LAST, 4'd3,  1'b1, 1'b1, 8'd0,   8'd25,  8'd25,  8'd0},
    '{PROG_STROBE,    4'd9,  1'b0, 1'b1, 8'd255, 8'd0,   8'd0,   8'd0},
    '{PROG_STROBE,    4'd9,  1'b1, 1'b0, 8'd0,   8'd0,   8'd0,   8'd0},
    '{PROG_STROBE,    4'd0,  1'b1, 1'b1, 8'd255, 8'd0,   8'd0,   8'd0},
    '{PROG_RAMP,      4'd0,  1'b1, 1'b1, 8'd0,   8'd0,   8'd0,   8'd0},
    '{PROG_RAMP,      4'd9,  1'b1, 1'b0, 8'd0,   8'd0,   8'd0,   8'd0},
    '{PROG_RAMP,      4'd9,  1'b1, 1'b0, 8'd0,   8'd0,   8'd0,   8'd0},
    '{PROG_RAMP,      4'd9,  1'b0, 1'b0, 8'd0,   8'd0,   8'd0,   8'd0},
    '{PROG_CROSS,     4'd0,  1'b1, 1'b1, 8'd0,   8'd0,   8'd0,   8'd0},
    '{PROG_CROSS,     4'd9,  1'b1, 1'b0, 8'd0,   8'd0,   8'd0,   8'd0},
    '{PROG_CROSS,     4'd9,  1'b1, 1'b0, 8'd0,   8'd0,   8'd0,   8'd0},
    '{PROG_CROSS,     4'd9,  1'b1, 1'b0, 8'd0,   8'd0,   8'd0,   8'd0},
    '{PROG_RAMP,      4'd9,  1'b1, 1'b0, 8'd0,   8'd0,   8'd0,   8'd0},
    '{PROG_RAMP,      4'd9,  1'b1, 1'b0, 8'd0,   8'd0,   8'd0,   8'd0},
    '{PROG_RAMP,      4'd9,  1'b1, 1'b0, 8'd0,   8'd0,   8'd0,   8'd0}
  };

  typedef struct packed {
    logic      known;
    out_item_t levels;
  } fixed_levels_t;

  logic clk;
  logic rst;
  logic                     cfg_we;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0]  cfg_data;

  lps_in_if  in_ch ();
  lps_out_if out_ch ();

  led_lighting_program_sequencer_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of the configuration and state
  logic [7:0] fade_top;
  logic       white_own;
  logic [3:0] seq_phase;
  logic [9:0] seq_timer;
  logic [3:0] flashes_left;
  logic [7:0] fade_lvl;
  logic [3:0] last_prog;
  logic [3:0] last_depth;
  logic       restart_due;
  out_item_t  shown;

  out_item_t     levels_due [$];
  fixed_levels_t fixed_levels_q [$];
  int  sent_count;
  int  results_seen;
  int  errors;
  int  stall_cycles;
  bit  calm;
  bit  long_hold_done;
  int  run_left;
  logic [3:0] run_prog;
  logic [3:0] run_depth;
  string field_name [4] = '{"red", "green", "blue", "white"};

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void clear_levels_model();
    fade_top     = LEVEL_FULL;
    white_own    = 1'b0;
    seq_phase    = '0;
    seq_timer    = '0;
    flashes_left = '0;
    fade_lvl     = '0;
    last_prog    = '0;
    last_depth   = '0;
    restart_due  = 1'b1;
    shown        = '0;
  endfunction

  // one colour at level v, white by the white routing setting
  function automatic out_item_t colour_levels(input logic [3:0] colour, input logic [7:0] v);
    out_item_t r;
    logic [3:0] m;
    r = '0;
    m = COLOUR_MASK[colour];
    if (m[3]) begin
      if (white_own) begin
        r.white_level = v;
      end else begin
        r.red_level   = v;
        r.green_level = v;
        r.blue_level  = v;
      end
    end else begin
      if (m[0]) r.red_level = v;
      if (m[1]) r.green_level = v;
      if (m[2]) r.blue_level = v;
    end
    return r;
  endfunction

  // strobe: flash each colour, dark between flashes
  function automatic void strobe_step(input logic [3:0] dp);
    if (restart_due) begin
      restart_due  = 1'b0;
      seq_phase    = '0;
      seq_timer    = '0;
      flashes_left = FLASH_COUNT[dp];
    end
    if (seq_phase > PHASE_SEQ_LAST) begin
      seq_phase = '0;
    end else if (seq_timer == 0) begin
      seq_timer = STROBE_PERIOD[dp] >> 1;
      if (!seq_phase[0]) begin
        shown = colour_levels(seq_phase >> 1, LEVEL_FULL);
        seq_phase = seq_phase + 4'd1;
      end else begin
        shown = '0;
        if (flashes_left > 1) begin
          flashes_left = flashes_left - 4'd1;
          seq_phase = seq_phase - 4'd1;
        end else begin
          flashes_left = FLASH_COUNT[dp];
          seq_phase = (seq_phase == PHASE_SEQ_LAST) ? 4'd0 : seq_phase + 4'd1;
        end
      end
    end
  endfunction

  // fade: ramp each colour up to the ceiling and back down
  function automatic void fade_step(input logic [3:0] dp);
    if (restart_due) begin
      restart_due = 1'b0;
      seq_phase   = '0;
      seq_timer   = '0;
    end
    if (seq_phase > PHASE_SEQ_LAST) begin
      seq_phase = '0;
    end else if (seq_timer == 0) begin
      if (!seq_phase[0]) begin
        if (fade_lvl < fade_top) begin
          shown = colour_levels(seq_phase >> 1, fade_lvl);
          fade_lvl = fade_lvl + 8'd1;
        end else begin
          seq_phase = seq_phase + 4'd1;
        end
      end else begin
        if (fade_lvl != 0) begin
          shown = colour_levels(seq_phase >> 1, fade_lvl);
          fade_lvl = fade_lvl - 8'd1;
        end else begin
          seq_phase = (seq_phase == PHASE_SEQ_LAST) ? 4'd0 : seq_phase + 4'd1;
        end
      end
      seq_timer = FADE_STEP[dp];
    end
  endfunction

  function automatic void cross_restart();
    seq_phase = '0;
    seq_timer = '0;
    fade_lvl  = '0;
    shown     = '0;
  endfunction

  // cross-fade: rising colour against falling one, shared channel takes the larger
  function automatic void cross_step(input logic [3:0] dp);
    logic [7:0] up;
    logic [7:0] dn;
    logic [7:0] mx;
    if (restart_due) begin
      restart_due = 1'b0;
      cross_restart();
    end
    if (seq_phase > PHASE_CROSS_LAST) begin
      cross_restart();
    end else if (seq_timer == 0) begin
      if (fade_lvl < fade_top) begin
        up = fade_lvl;
        dn = fade_top - fade_lvl;
        mx = (up > dn) ? up : dn;
        case (seq_phase)
          4'd0: shown = colour_levels(COLOUR_WHITE, up);
          4'd1: begin
            if (white_own) shown = out_item_t'{up, 8'd0, 8'd0, dn};
            else shown = out_item_t'{mx, dn, dn, 8'd0};
          end
          4'd2: shown = out_item_t'{dn, up, 8'd0, 8'd0};
          4'd3: shown = out_item_t'{8'd0, dn, up, 8'd0};
          4'd4: shown = out_item_t'{up, 8'd0, mx, 8'd0};
          4'd5: shown = out_item_t'{mx, up, dn, 8'd0};
          4'd6: shown = out_item_t'{dn, mx, up, 8'd0};
          default: begin
            if (white_own) shown = out_item_t'{8'd0, dn, dn, up};
            else shown = out_item_t'{up, mx, mx, 8'd0};
          end
        endcase
        fade_lvl = fade_lvl + 8'd1;
      end else begin
        seq_phase = (seq_phase == PHASE_CROSS_LAST) ? 4'd1 : seq_phase + 4'd1;
        fade_lvl  = '0;
      end
      seq_timer = FADE_STEP[dp];
    end
  endfunction

  // levels after one request
  function automatic out_item_t next_levels(input in_item_t rq);
    logic [3:0] pg;
    logic [3:0] dp;
    pg = rq.program_sel;
    dp = rq.depth_sel;
    if (rq.tick && seq_timer != 0) seq_timer = seq_timer - 10'd1;
    if (pg >= PROG_FIRST && pg <= PROG_CROSS && dp <= DEPTH_LAST) begin
      if (pg != last_prog || dp != last_depth) begin
        last_prog   = pg;
        last_depth  = dp;
        restart_due = 1'b1;
      end
      if (pg <= PROG_STATIC_LAST) begin
        if (restart_due) begin
          restart_due = 1'b0;
          shown = colour_levels(pg - PROG_FIRST, STATIC_LEVEL[dp]);
        end
      end else if (pg == PROG_STROBE) begin
        strobe_step(dp);
      end else if (pg == PROG_RAMP) begin
        fade_step(dp);
      end else begin
        cross_step(dp);
      end
    end
    return shown;
  endfunction

  // random request: runs of one program and depth, with some invalid noise
  function automatic in_item_t next_request();
    in_item_t rq;
    int sel;
    if (run_left == 0) begin
      sel = $urandom_range(0, 19);
      if (sel < 4) run_prog = 4'($urandom_range(PROG_FIRST, PROG_STATIC_LAST));
      else if (sel < 9) run_prog = PROG_STROBE;
      else if (sel < 14) run_prog = PROG_RAMP;
      else run_prog = PROG_CROSS;
      run_depth = $urandom_range(0, 1) ? DEPTH_LAST : 4'($urandom_range(0, DEPTH_LAST));
      run_left = $urandom_range(4, 80);
    end
    run_left--;
    if ($urandom_range(0, 9) == 0) begin
      rq.program_sel = 4'($urandom_range(0, 15));
      rq.depth_sel   = 4'($urandom_range(0, 15));
      if (rq.program_sel >= PROG_FIRST && rq.program_sel <= PROG_CROSS &&
          rq.depth_sel <= DEPTH_LAST)
        rq.depth_sel = 4'($urandom_range(10, 15));
      rq.tick = 1'($urandom_range(0, 1));
    end else begin
      rq.program_sel = run_prog;
      rq.depth_sel   = run_depth;
      rq.tick        = ($urandom_range(0, 7) != 0);
    end
    return rq;
  endfunction

  // offer one request and hold it until taken
  task automatic send_request(input in_item_t rq, input logic known, input out_item_t lv);
    fixed_levels_q.push_back(fixed_levels_t'{known, lv});
    in_ch.valid <= 1'b1;
    in_ch.data  <= rq;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
  endtask

  // random idle burst on the request side
  task automatic request_gap();
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // stop offering and wait for every level update to come back
  task automatic wait_all_levels();
    in_ch.valid <= 1'b0;
    while (results_seen < sent_count) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write both registers back to back
  task automatic set_config(input logic [7:0] ceiling, input logic white);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FADE_CEILING;
    cfg_data  <= ceiling;
    @(posedge clk);
    cfg_index <= REG_WHITE_SEPARATE;
    cfg_data  <= {7'd0, white};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // prediction on taken requests, config writes, and result checking
  always @(posedge clk) begin
    out_item_t     got;
    out_item_t     want;
    fixed_levels_t row;
    logic [31:0]   want_bits;
    logic [31:0]   got_bits;
    if (rst) begin
      clear_levels_model();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FADE_CEILING:   fade_top  = cfg_data;
          REG_WHITE_SEPARATE: white_own = cfg_data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        want = next_levels(in_ch.data);
        if (fixed_levels_q.size() != 0) begin
          row = fixed_levels_q.pop_front();
          if (row.known) want = row.levels;
        end
        levels_due.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        got = out_ch.data;
        if (levels_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got %h", $time, got);
        end else begin
          want_bits = levels_due.pop_front();
          got_bits  = got;
          for (int k = 0; k < 4; k++) begin
            if (want_bits[31 - 8 * k -: 8] !== got_bits[31 - 8 * k -: 8]) begin
              errors++;
              $display("%0t: %s level mismatch, expected %0d, got %0d", $time,
                       field_name[k], want_bits[31 - 8 * k -: 8], got_bits[31 - 8 * k -: 8]);
            end
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold to back up the pipeline
  initial begin
    out_ch.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (!long_hold_done && results_seen >= 60) begin
        out_ch.ready <= 1'b0;
        long_hold_done = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // request side: reset, directed table, then random phases over several settings
  initial begin
    directed_row_t d;
    in_item_t      rq;
    rst            = 1'b1;
    in_ch.valid    = 1'b0;
    in_ch.data     = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    sent_count     = 0;
    results_seen   = 0;
    errors         = 0;
    stall_cycles   = 0;
    calm           = 1'b0;
    long_hold_done = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    set_config(LEVEL_FULL, 1'b0);

    // directed table
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      d = DIRECTED[i];
      rq.program_sel = d.pg;
      rq.depth_sel   = d.dp;
      rq.tick        = d.tk;
      send_request(rq, d.known, out_item_t'{d.r, d.g, d.b, d.w});
      request_gap();
    end

    // random phases; the fade run carries into the low ceiling of the first
    run_prog  = PROG_RAMP;
    run_depth = DEPTH_LAST;
    run_left  = 20;
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_all_levels();
      set_config(PHASE_CEILING[p], PHASE_WHITE[p]);
      calm = (p == NUM_PHASES - 1);
      if (p == 1) begin
        // long strobe run to get past the first colour
        run_prog  = PROG_STROBE;
        run_depth = DEPTH_LAST;
        run_left  = 1100;
      end
      for (int n = 0; n < ((p == 1) ? 1200 : 120); n++) begin
        send_request(next_request(), 1'b0, '0);
        request_gap();
      end
    end

    wait_all_levels();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
